// ----- sv/nec_ird_pkg.sv -----
// Shared types, register indexes and helpers for the NEC IR frame decoder.
// Used by the step logic, the top level and the port checker; no dependencies.
package nec_ird_pkg;

   localparam int TIME_W      = 16;
   localparam int COUNT_W     = 6;
   localparam int BITS_W      = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 32;

   localparam logic [COUNT_W-1:0] FIRST_DATA_EDGE = 6'd3;
   localparam logic [COUNT_W-1:0] FRAME_EDGES     = 6'd34;
   localparam logic [COUNT_W-1:0] RESTART_COUNT   = 6'd1;
   localparam logic [7:0]         BYTE_MASK       = 8'hFF;

   localparam logic [TIME_W-1:0] ONE_THRESHOLD_RESET = 16'd1800;
   localparam logic [TIME_W-1:0] GAP_LIMIT_RESET     = 16'd3000;
   localparam logic [7:0]        START_CODE_RESET    = 8'h10;
   localparam logic [7:0]        STOP_CODE_RESET     = 8'h11;

   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_ADDRESS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_THRESHOLD    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_LIMIT        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_CODE       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_CODE        = 3'd4;

   typedef enum logic [1:0] {
      STATUS_VALID        = 2'd0,
      STATUS_ADDR_MISMATCH = 2'd1,
      STATUS_INVERSE_FAIL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2
   } command_type;

   typedef struct packed {
      logic [TIME_W-1:0] expected_address;
      logic [TIME_W-1:0] one_threshold_ticks;
      logic [TIME_W-1:0] gap_limit_ticks;
      logic [7:0]        start_code;
      logic [7:0]        stop_code;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]  last_edge_time;
      logic [COUNT_W-1:0] edge_count;
      logic [BITS_W-1:0]  frame_bits;
   } state_type;

   typedef struct packed {
      command_type       command;
      logic [7:0]        command_byte;
      logic [TIME_W-1:0] address;
      status_type        frame_status;
   } result_type;

   function automatic logic [7:0] flip_byte(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

endpackage

// ----- sv/nec_ir_frame_decoder_core.sv -----
// Top level of the NEC-extended IR frame decoder: request register, decode
// step, result register and configuration registers. Depends on nec_ird_pkg
// and nec_ird_step.
//
// Usage:
//   req_* carries one falling-edge capture time per request (tdata[15:0]).
//   rsp_* carries one result per completed frame; edges that do not
//   end a frame produce no result. csr_* writes the five setup registers;
//   the user must write them only while the block is idle; the block does not enforce this.
// Flow: a request lands in the request register at the accepting edge,
//   is decoded at the next edge that it can leave that register, and its
//   result is shown on rsp_* from that edge on.
// Throughput: one request per cycle unless a frame ends while a result waits,
//   set by the single decode step between the request register and the result register.
// Reset: clears the edge count, the last capture time, the shift register,
//   both valid flags, and loads the register reset values.
// Stall: while a result waits, one more request is taken into the request
//   register; it is decoded as soon as the result is taken, or at once when
//   it ends no frame.
module nec_ir_frame_decoder_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [nec_ird_pkg::REQ_DATA_W-1:0]     req_tdata,   // [15:0] capture_time
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [1:0] frame_status, [17:2] address, [25:18] command_byte, [27:26] command,
   // [31:28] zero
   output logic [nec_ird_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                   csr_we,
   input  logic [nec_ird_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [nec_ird_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import nec_ird_pkg::*;

   cfg_type           cfg_ff;
   state_type         state_ff;
   state_type         state_in;
   logic              req_valid_ff;
   logic [TIME_W-1:0] req_time_ff;
   logic              rsp_valid_ff;
   result_type        rsp_data_ff;
   logic              emit;
   result_type        result;
   logic              advance;
   logic              rsp_free;

   nec_ird_step u_step (
      .cfg          (cfg_ff),
      .state        (state_ff),
      .capture_time (req_time_ff),
      .state_next   (state_in),
      .emit         (emit),
      .result       (result)
   );

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = req_valid_ff && (rsp_free || !emit);
   assign req_tready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_address    <= '0;
         cfg_ff.one_threshold_ticks <= ONE_THRESHOLD_RESET;
         cfg_ff.gap_limit_ticks     <= GAP_LIMIT_RESET;
         cfg_ff.start_code          <= START_CODE_RESET;
         cfg_ff.stop_code           <= STOP_CODE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EXPECTED_ADDRESS: cfg_ff.expected_address    <= csr_wdata;
            CSR_ONE_THRESHOLD:    cfg_ff.one_threshold_ticks <= csr_wdata;
            CSR_GAP_LIMIT:        cfg_ff.gap_limit_ticks     <= csr_wdata;
            CSR_START_CODE:       cfg_ff.start_code          <= csr_wdata[7:0];
            CSR_STOP_CODE:        cfg_ff.stop_code           <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_time_ff <= req_tdata[TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

endmodule

// ----- sv/nec_ird_step.sv -----
// Per-edge decode step: interval, bit shift, frame check and command mapping.
// Depends on nec_ird_pkg.
module nec_ird_step (
   input  nec_ird_pkg::cfg_type                  cfg,
   input  nec_ird_pkg::state_type                state,
   input  logic [nec_ird_pkg::TIME_W-1:0]        capture_time,
   output nec_ird_pkg::state_type                state_next,
   output logic                                  emit,
   output nec_ird_pkg::result_type               result
);
   import nec_ird_pkg::*;

   logic [TIME_W-1:0]  interval;
   logic [COUNT_W-1:0] count_inc;
   logic               in_data;
   logic               gap;
   logic               done;
   logic [BITS_W-1:0]  shifted;
   logic [7:0]         lo_byte;
   logic [7:0]         hi_byte;
   logic [7:0]         cmd_byte;
   logic [7:0]         inv_byte;
   logic [TIME_W-1:0]  addr;
   status_type         status;

   assign interval  = capture_time - state.last_edge_time;
   assign count_inc = state.edge_count + 6'd1;
   assign in_data   = (count_inc >= FIRST_DATA_EDGE) && (count_inc <= FRAME_EDGES);
   assign gap       = in_data && (interval > cfg.gap_limit_ticks);
   assign shifted   = {state.frame_bits[BITS_W-2:0], interval >= cfg.one_threshold_ticks};
   assign done      = in_data && !gap && (count_inc == FRAME_EDGES);

   assign lo_byte  = flip_byte(shifted[31:24]);
   assign hi_byte  = flip_byte(shifted[23:16]);
   assign cmd_byte = flip_byte(shifted[15:8]);
   assign inv_byte = flip_byte(shifted[7:0]);
   assign addr     = {hi_byte, lo_byte};

   always_comb begin
      state_next.last_edge_time = capture_time;
      priority if (gap) begin
         state_next.edge_count = RESTART_COUNT;
         state_next.frame_bits = '0;
      end else if (done) begin
         state_next.edge_count = '0;
         state_next.frame_bits = '0;
      end else begin
         state_next.edge_count = count_inc;
         state_next.frame_bits = in_data ? shifted : state.frame_bits;
      end
   end

   always_comb begin
      priority if (addr != cfg.expected_address) begin
         status = STATUS_ADDR_MISMATCH;
      end else if ((cmd_byte ^ inv_byte) != BYTE_MASK) begin
         status = STATUS_INVERSE_FAIL;
      end else begin
         status = STATUS_VALID;
      end
   end

   always_comb begin
      result.frame_status = status;
      result.address      = addr;
      result.command_byte = cmd_byte;
      priority if (status != STATUS_VALID) begin
         result.command = CMD_NONE;
      end else if (cmd_byte == cfg.start_code) begin
         result.command = CMD_START;
      end else if (cmd_byte == cfg.stop_code) begin
         result.command = CMD_STOP;
      end else begin
         result.command = CMD_NONE;
      end
   end

   assign emit = done;

endmodule

// ----- sv/nec_ird_checker.sv -----
// Port-level checks for the NEC IR frame decoder, bound to the top level.
// Depends on nec_ird_pkg and nec_ir_frame_decoder_core.
module nec_ird_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [nec_ird_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import nec_ird_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == STATUS_VALID ||
                      rsp_tdata[1:0] == STATUS_ADDR_MISMATCH ||
                      rsp_tdata[1:0] == STATUS_INVERSE_FAIL))
      else $error("illegal frame status");

   a_command_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[27:26] != CMD_NONE) |->
         (rsp_tdata[1:0] == STATUS_VALID && rsp_tdata[31:28] == 4'b0000))
      else $error("command mapped on failed frame");

endmodule

bind nec_ir_frame_decoder_core nec_ird_checker u_nec_ird_checker (.*);

// ----- tb/nec_ir_frame_decoder_core_tb.sv -----
// Self-checking bench for nec_ir_frame_decoder_core: NEC edge streams, directed then random,
// checked against an in-bench frame decoder, or typed directed rows against their own results,
// under several register setups. Depends on nec_ird_pkg and the nec_ir_frame_decoder_core RTL.
module nec_ir_frame_decoder_core_tb;
   import nec_ird_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 6;
   localparam int DIR_ROWS = 9;
   localparam int PHASES = 6;
   localparam logic [TIME_W-1:0] LEADER_TICKS = 16'd13500;

   typedef struct packed {
      logic [TIME_W-1:0] base;
      logic [TIME_W-1:0] zero_iv;
      logic [TIME_W-1:0] one_iv;
      logic [31:0]       payload;
      logic [5:0]        nbits;
      logic              typed;
      status_type        st;
      logic [TIME_W-1:0] addr;
      logic [7:0]        cb;
      command_type       cmd;
   } frame_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   cfg_type            cfg;
   logic [TIME_W-1:0]  dec_last_time = '0;
   logic [COUNT_W-1:0] dec_edge_count = '0;
   logic [BITS_W-1:0]  dec_bits = '0;
   result_type         frames_due[$];
   result_type         typed_frame;
   result_type         want, got;
   bit                 typed_armed = 1'b0;
   bit                 quiet = 1'b0;
   int                 stall_left = 0;
   int                 errors = 0;
   int                 cycles = 0;
   int                 edges_sent = 0;
   int                 frames_decoded = 0;
   int                 frames_checked = 0;
   int                 setups = 1;

   nec_ir_frame_decoder_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [15:0] capture_time
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // [1:0] frame_status, [17:2] address, [25:18] command_byte, [27:26] command, [31:28] zero
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [7:0] reverse8(input logic [7:0] v);
      return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
   endfunction

   function automatic bit decode_edge(input logic [TIME_W-1:0] t, output result_type r);
      logic [TIME_W-1:0] dt;
      logic [7:0]        lo, hi, cb, inv;
      dt = t - dec_last_time;
      dec_last_time = t;
      dec_edge_count = dec_edge_count + 6'd1;
      r = '0;
      if (dec_edge_count >= FIRST_DATA_EDGE && dec_edge_count <= FRAME_EDGES) begin
         if (dt > cfg.gap_limit_ticks) begin
            dec_edge_count = RESTART_COUNT;
            dec_bits = '0;
            return 1'b0;
         end
         dec_bits = {dec_bits[BITS_W-2:0], dt >= cfg.one_threshold_ticks};
      end
      if (dec_edge_count != FRAME_EDGES) return 1'b0;
      lo = reverse8(dec_bits[31:24]);
      hi = reverse8(dec_bits[23:16]);
      cb = reverse8(dec_bits[15:8]);
      inv = reverse8(dec_bits[7:0]);
      r.address = {hi, lo};
      r.command_byte = cb;
      if (r.address != cfg.expected_address) begin
         r.frame_status = STATUS_ADDR_MISMATCH;
      end else if ((cb ^ inv) != BYTE_MASK) begin
         r.frame_status = STATUS_INVERSE_FAIL;
      end else begin
         r.frame_status = STATUS_VALID;
      end
      r.command = CMD_NONE;
      if (r.frame_status == STATUS_VALID) begin
         if (cb == cfg.start_code) begin
            r.command = CMD_START;
         end else if (cb == cfg.stop_code) begin
            r.command = CMD_STOP;
         end
      end
      dec_bits = '0;
      dec_edge_count = '0;
      return 1'b1;
   endfunction

   // base, zero/one intervals, payload {inv, cmd, addr_hi, addr_lo}, data bits, typed result
   function automatic frame_row_type directed_row(input int k);
      case (k)
         0: return {16'h0000, 16'd1125, 16'd2250, 32'hEF10_0000, 6'd32,
                    1'b1, STATUS_VALID, 16'h0000, 8'h10, CMD_START};
         1: return {16'h4000, 16'd1125, 16'd2250, 32'hEE11_0000, 6'd32,
                    1'b1, STATUS_VALID, 16'h0000, 8'h11, CMD_STOP};
         2: return {16'hFFFF, 16'd1125, 16'd2250, 32'hFF00_0000, 6'd32,
                    1'b1, STATUS_VALID, 16'h0000, 8'h00, CMD_NONE};
         3: return {16'h8000, 16'd1799, 16'd1800, 32'h00FF_0000, 6'd32,
                    1'b1, STATUS_VALID, 16'h0000, 8'hFF, CMD_NONE};
         4: return {16'h1234, 16'd0, 16'd3000, 32'h1234_FFFF, 6'd32,
                    1'b1, STATUS_ADDR_MISMATCH, 16'hFFFF, 8'h34, CMD_NONE};
         5: return {16'hC000, 16'd1125, 16'd2250, 32'h1010_0000, 6'd32,
                    1'b1, STATUS_INVERSE_FAIL, 16'h0000, 8'h10, CMD_NONE};
         6: return {16'h2000, 16'd1125, 16'd2250, 32'h0000_0015, 6'd5,
                    1'b0, STATUS_VALID, 16'h0000, 8'h00, CMD_NONE};
         7: return {16'hF000, 16'd1125, 16'd2250, 32'hFFFF_FFFF, 6'd32,
                    1'b1, STATUS_ADDR_MISMATCH, 16'hFFFF, 8'hFF, CMD_NONE};
         default: return {16'h7FFF, 16'd1125, 16'd2250, 32'h6996_A55A, 6'd32,
                          1'b0, STATUS_VALID, 16'h0000, 8'h00, CMD_NONE};
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(99, 0);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [TIME_W-1:0] pick_interval(input logic b);
      int thr, gap;
      thr = int'(cfg.one_threshold_ticks);
      gap = int'(cfg.gap_limit_ticks);
      if ($urandom_range(3, 0) == 0) begin
         if (b) return TIME_W'((thr <= gap && $urandom_range(1, 0) == 1) ? thr : gap);
         return TIME_W'((thr > 0 && thr - 1 <= gap) ? thr - 1 : 0);
      end
      if (b) return TIME_W'((thr <= gap) ? $urandom_range(gap, thr) : gap);
      if (thr == 0) return TIME_W'($urandom_range(gap, 0));
      return TIME_W'($urandom_range((thr - 1 < gap) ? thr - 1 : gap, 0));
   endfunction

   task automatic send_edge(input logic [TIME_W-1:0] t);
      int         idle;
      result_type r;
      idle = pick_gap();
      if (idle > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (idle - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = t;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      edges_sent++;
      if (decode_edge(t, r)) begin
         frames_due.push_back(typed_armed ? typed_frame : r);
         frames_decoded++;
      end
   endtask

   task automatic send_frame(input logic [TIME_W-1:0] first_lead,
                             input logic [TIME_W-1:0] zero_iv,
                             input logic [TIME_W-1:0] one_iv,
                             input logic [31:0] payload, input int nbits,
                             input bit jitter, input bit cut_gap);
      bit                first;
      logic [TIME_W-1:0] iv;
      first = 1'b1;
      // align to the end of the leader
      while (dec_edge_count != FIRST_DATA_EDGE - 6'd1) begin
         if (dec_edge_count < FIRST_DATA_EDGE - 6'd1) begin
            send_edge(first ? first_lead : dec_last_time + LEADER_TICKS);
         end else if (cfg.gap_limit_ticks != 16'hFFFF) begin
            send_edge(dec_last_time + cfg.gap_limit_ticks + 16'd1);
         end else begin
            send_edge(dec_last_time + zero_iv);
         end
         first = 1'b0;
      end
      for (int i = 0; i < nbits; i++) begin
         iv = jitter ? pick_interval(payload[i]) : (payload[i] ? one_iv : zero_iv);
         send_edge(dec_last_time + iv);
      end
      if (cut_gap && cfg.gap_limit_ticks != 16'hFFFF) begin
         send_edge(dec_last_time + cfg.gap_limit_ticks + 16'd1);
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_EXPECTED_ADDRESS: cfg.expected_address = val;
         CSR_ONE_THRESHOLD:    cfg.one_threshold_ticks = val;
         CSR_GAP_LIMIT:        cfg.gap_limit_ticks = val;
         CSR_START_CODE:       cfg.start_code = val[7:0];
         CSR_STOP_CODE:        cfg.stop_code = val[7:0];
         default: ;
      endcase
   endtask

   task automatic apply_setup(input logic [15:0] addr, input logic [15:0] thr,
                              input logic [15:0] gap, input logic [7:0] sc,
                              input logic [7:0] pc);
      csr_write(CSR_EXPECTED_ADDRESS, addr);
      csr_write(CSR_ONE_THRESHOLD, thr);
      csr_write(CSR_GAP_LIMIT, gap);
      csr_write(CSR_START_CODE, {8'h00, sc});
      csr_write(CSR_STOP_CODE, {8'h00, pc});
      setups++;
   endtask

   task automatic check_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      end
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else begin
         rsp_tready = 1'b1;
         stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (frames_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
         end else begin
            want = frames_due.pop_front();
            got = rsp_tdata[27:0];
            check_field("frame_status", int'(want.frame_status), int'(got.frame_status));
            check_field("address", int'(want.address), int'(got.address));
            check_field("command_byte", int'(want.command_byte), int'(got.command_byte));
            check_field("command", int'(want.command), int'(got.command));
            check_field("pad", 0, int'(rsp_tdata[31:28]));
            frames_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, frames_due.size());
         $display("[nec_ir_frame_decoder_core] ERROR");
         $finish;
      end
   end

   initial begin
      frame_row_type     row;
      int                e0, f0, r;
      logic [7:0]        cb, inv;
      logic [15:0]       addr, thr;
      cfg = {16'h0000, ONE_THRESHOLD_RESET, GAP_LIMIT_RESET, START_CODE_RESET, STOP_CODE_RESET};
      repeat (9) @(negedge clock);
      reset = 1'b0;

      for (int k = 0; k < DIR_ROWS; k++) begin
         row = directed_row(k);
         typed_frame = {row.cmd, row.cb, row.addr, row.st};
         typed_armed = row.typed;
         send_frame(row.base, row.zero_iv, row.one_iv, row.payload, int'(row.nbits),
                    1'b0, row.nbits < 6'd32);
         typed_armed = 1'b0;
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: apply_setup(16'($urandom), ONE_THRESHOLD_RESET, GAP_LIMIT_RESET,
                           START_CODE_RESET, STOP_CODE_RESET);
            1: apply_setup(16'hFFFF, 16'h0000, 16'h0000, 8'h00, 8'hFF);
            2: apply_setup(16'h0000, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
            3: begin
               cb = 8'($urandom);
               apply_setup(16'($urandom), 16'd1, 16'd1, cb, cb);
            end
            4: begin
               thr = 16'($urandom_range(30000, 1));
               apply_setup(16'($urandom), thr,
                           16'(int'(thr) + int'($urandom_range(30000, 0))),
                           8'($urandom), 8'($urandom));
            end
            default: apply_setup(16'($urandom), 16'($urandom), 16'($urandom),
                                 8'($urandom), 8'($urandom));
         endcase
         e0 = edges_sent;
         f0 = frames_decoded;
         while (edges_sent - e0 < 150 || frames_decoded - f0 < 4) begin
            quiet = ($urandom_range(3, 0) == 0);
            addr = ($urandom_range(9, 0) < 6) ? cfg.expected_address : 16'($urandom);
            case ($urandom_range(4, 0))
               0: cb = cfg.start_code;
               1: cb = cfg.stop_code;
               default: cb = 8'($urandom);
            endcase
            inv = ($urandom_range(3, 0) != 0) ? ~cb : 8'($urandom);
            r = $urandom_range(99, 0);
            if (r < 80) begin
               send_frame(16'($urandom), 16'd0, 16'd0, {inv, cb, addr}, 32, 1'b1, 1'b0);
            end else if (r < 90) begin
               send_frame(16'($urandom), 16'd0, 16'd0, {inv, cb, addr},
                          int'($urandom_range(31, 0)), 1'b1, 1'b1);
            end else begin
               repeat ($urandom_range(8, 1)) send_edge(16'($urandom));
            end
         end
      end
      quiet = 1'b0;
      settle();

      $display("run: %0d capture edges, %0d frames checked, %0d register setups",
               edges_sent, frames_checked, setups);
      if (errors == 0) begin
         $display("[nec_ir_frame_decoder_core] OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("[nec_ir_frame_decoder_core] ERROR");
      end
      $finish;
   end
endmodule
